### hw/rtl/ulaq_pkg.sv
package ulaq_pkg;

	localparam int LINE_LEN    = 64;
	localparam int QUEUE_DEPTH = 8;

	localparam int LEN_W  = $clog2(LINE_LEN);
	localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(QUEUE_DEPTH * LINE_LEN);
	localparam int LIM_W  = 7;
	localparam int CMP_W  = (LEN_W > LIM_W) ? LEN_W : LIM_W;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	localparam logic CMD_RX  = 1'b0;
	localparam logic CMD_POP = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [7:0]       rx_byte;
		logic [LIM_W-1:0] out_limit;
	} req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       queue_was_empty;
		logic       last;
		logic [3:0] lines_held;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_POP
	} state_t;

	typedef struct packed {
		logic is_pop;
		logic is_term;
		logic partial_empty;
		logic partial_full;
		logic keep_empty;
		logic queue_full;
		logic queue_empty;
		logic pop_none;
		logic step_last;
	} status_t;

	typedef struct packed {
		logic append;
		logic clear_line;
		logic push_commit;
		logic copy_step;
		logic pop_commit;
		logic read_step;
		logic emit_flag;
	} ctrl_t;

endpackage

### hw/rtl/ulaq_ctrl.sv
module ulaq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ulaq_pkg::status_t status,
	output ulaq_pkg::ctrl_t   ctrl,
	output logic              busy
);
	import ulaq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					priority if (status.is_pop) begin
						if (status.queue_empty) begin
							ctrl.emit_flag = 1'b1;
						end else begin
							ctrl.pop_commit = 1'b1;
							if (status.pop_none) begin
								ctrl.emit_flag = 1'b1;
							end else begin
								state_d = ST_POP;
							end
						end
					end else if (status.is_term && status.partial_empty) begin
						// bare terminator: nothing to do
					end else if (!status.is_term && !status.partial_full) begin
						ctrl.append = 1'b1;
					end else begin
						ctrl.clear_line = 1'b1;
						if (!status.queue_full) begin
							ctrl.push_commit = 1'b1;
							if (!status.keep_empty) begin
								state_d = ST_COPY;
							end
						end
					end
				end
			end
			ST_COPY: begin
				ctrl.copy_step = 1'b1;
				if (status.step_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				ctrl.read_step = 1'b1;
				if (status.step_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### hw/rtl/ulaq_datapath.sv
module ulaq_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ulaq_pkg::req_t    req,
	input  ulaq_pkg::ctrl_t   ctrl,
	output ulaq_pkg::status_t status,
	output ulaq_pkg::rsp_t    result,
	output logic              result_strobe
);
	import ulaq_pkg::*;

	logic [7:0]       partial_mem [LINE_LEN];
	logic [7:0]       store_mem   [QUEUE_DEPTH * LINE_LEN];
	logic [LEN_W-1:0] len_mem     [QUEUE_DEPTH];

	logic [LEN_W-1:0]  partial_len_q;
	logic [LEN_W-1:0]  keep_len_q;
	logic              seen_zero_q;
	logic [SLOT_W-1:0] wr_slot_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [LEN_W-1:0]  idx_q;
	logic [SLOT_W-1:0] base_q;
	logic [LEN_W-1:0]  n_q;
	logic              copy_we_s1;
	logic [ADDR_W-1:0] copy_addr_s1;
	logic [7:0]        copy_data_s1;
	rsp_t              result_q;
	logic              strobe_q;

	logic [CMP_W-1:0]  lim_m1;
	logic [LEN_W-1:0]  head_len;
	logic [LEN_W-1:0]  pop_n;
	logic [SLOT_W-1:0] wr_next;
	logic [SLOT_W-1:0] rd_next;
	logic [ADDR_W-1:0] mem_addr;

	assign lim_m1   = (req.out_limit == '0) ? '0 : CMP_W'(req.out_limit - 1'b1);
	assign head_len = len_mem[rd_slot_q];
	assign pop_n    = (CMP_W'(head_len) < lim_m1) ? head_len : LEN_W'(lim_m1);
	assign wr_next  = (wr_slot_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : wr_slot_q + 1'b1;
	assign rd_next  = (rd_slot_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : rd_slot_q + 1'b1;
	assign mem_addr = ADDR_W'(base_q * LINE_LEN + idx_q);

	always_comb begin
		status               = '0;
		status.is_pop        = (req.cmd == CMD_POP);
		status.is_term       = (req.rx_byte == CHAR_CR) || (req.rx_byte == CHAR_LF);
		status.partial_empty = (partial_len_q == '0);
		status.partial_full  = (partial_len_q == LEN_W'(LINE_LEN - 1));
		status.keep_empty    = (keep_len_q == '0);
		status.queue_full    = (count_q == CNT_W'(QUEUE_DEPTH));
		status.queue_empty   = (count_q == '0);
		status.pop_none      = (pop_n == '0);
		status.step_last     = (LEN_W'(idx_q + 1'b1) == n_q);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_len_q <= '0;
			keep_len_q    <= '0;
			seen_zero_q   <= 1'b0;
			wr_slot_q     <= '0;
			rd_slot_q     <= '0;
			count_q       <= '0;
			idx_q         <= '0;
			copy_we_s1    <= 1'b0;
			strobe_q      <= 1'b0;
		end else begin
			if (ctrl.clear_line) begin
				partial_len_q <= '0;
				keep_len_q    <= '0;
				seen_zero_q   <= 1'b0;
			end else if (ctrl.append) begin
				partial_len_q <= partial_len_q + 1'b1;
				if (!seen_zero_q && req.rx_byte != CHAR_NUL) begin
					keep_len_q <= keep_len_q + 1'b1;
				end
				if (req.rx_byte == CHAR_NUL) begin
					seen_zero_q <= 1'b1;
				end
			end
			if (ctrl.push_commit) begin
				wr_slot_q <= wr_next;
				count_q   <= count_q + 1'b1;
				idx_q     <= '0;
			end else if (ctrl.pop_commit) begin
				rd_slot_q <= rd_next;
				count_q   <= count_q - 1'b1;
				idx_q     <= '0;
			end else if (ctrl.copy_step || ctrl.read_step) begin
				idx_q <= idx_q + 1'b1;
			end
			copy_we_s1 <= ctrl.copy_step;
			strobe_q   <= ctrl.emit_flag || ctrl.read_step;
		end
	end

	// transfer descriptor
	always_ff @(posedge clk) begin
		if (ctrl.push_commit) begin
			base_q <= wr_slot_q;
			n_q    <= keep_len_q;
		end else if (ctrl.pop_commit) begin
			base_q <= rd_slot_q;
			n_q    <= pop_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.append) begin
			partial_mem[partial_len_q] <= req.rx_byte;
		end
		copy_data_s1 <= partial_mem[idx_q];
		copy_addr_s1 <= mem_addr;
	end

	always_ff @(posedge clk) begin
		if (ctrl.push_commit) begin
			len_mem[wr_slot_q] <= keep_len_q;
		end
	end

	always_ff @(posedge clk) begin
		if (copy_we_s1) begin
			store_mem[copy_addr_s1] <= copy_data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.read_step) begin
			result_q.out_char        <= store_mem[mem_addr];
			result_q.char_valid      <= 1'b1;
			result_q.queue_was_empty <= 1'b0;
			result_q.last            <= status.step_last;
			result_q.lines_held      <= 4'(count_q);
		end else if (ctrl.emit_flag) begin
			result_q.out_char        <= CHAR_NUL;
			result_q.char_valid      <= 1'b0;
			result_q.queue_was_empty <= status.queue_empty;
			result_q.last            <= 1'b1;
			result_q.lines_held      <= status.queue_empty ? 4'd0 : 4'(count_q - 1'b1);
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("line count beyond queue depth");

	a_ring_match: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_slot_q == rd_slot_q) == (count_q == '0 || count_q == CNT_W'(QUEUE_DEPTH)))
		else $error("ring pointers disagree with line count");

	a_char_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.char_valid |-> !result.queue_was_empty)
		else $error("character result flagged as empty queue");

	a_copy_step_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.copy_step |-> !ctrl.read_step && !ctrl.append && !ctrl.pop_commit)
		else $error("copy overlaps another operation");
`endif

endmodule

### hw/rtl/uart_line_assembler_queue_top.sv
// Received byte: taken without going busy, no result.
// Line push: busy while the kept bytes of the pending line are copied into the queue RAM.
// Pop: characters stream out back to back, read in ST_POP then registered; busy while in ST_POP.
// Empty queue or nothing to emit: a single flagged result, registered, in the cycle after the request.
// Results are one-cycle strobes; the receiver cannot stall.
// Reset clears pointers, counts and the pending line length; line RAM contents are not cleared.
module uart_line_assembler_queue_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ulaq_pkg::req_t req,
	output ulaq_pkg::rsp_t result,
	output logic           result_strobe
);
	import ulaq_pkg::*;

	status_t status;
	ctrl_t   ctrl;

	// Sequence each request: append, push a finished line, or stream a pop.
	ulaq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Hold the pending line, the queued lines and the result register.
	ulaq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.ctrl          (ctrl),
		.status        (status),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

### tb/uart_line_assembler_queue_top_tb.sv
`timescale 1ns / 100ps

module uart_line_assembler_queue_top_tb;
	import ulaq_pkg::*;

	// Line assembler and ring queue predictor plus the store of expected pop results.
	class line_fifo_checker;
		logic [7:0] pend_bytes [LINE_LEN];
		int         pend_len;
		logic [7:0] slot_bytes [QUEUE_DEPTH][LINE_LEN];
		int         slot_len [QUEUE_DEPTH];
		int         wr_ptr;
		int         rd_ptr;
		int         held;
		rsp_t       expected_chars [$];
		int         fails;

		function new();
			pend_len = 0;
			wr_ptr   = 0;
			rd_ptr   = 0;
			held     = 0;
			fails    = 0;
		endfunction

		// Copy the pending line into the queue, cut at its first zero byte.
		function void push_line();
			int n;
			n = 0;
			if (held >= QUEUE_DEPTH)
				return;
			while (n < pend_len && n < LINE_LEN - 1 && pend_bytes[n] != CHAR_NUL)
				n++;
			for (int i = 0; i < n; i++)
				slot_bytes[wr_ptr][i] = pend_bytes[i];
			slot_len[wr_ptr] = n;
			wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
			held++;
		endfunction

		function void add_expect(logic [7:0] ch, logic valid, logic was_empty, logic last_flag);
			rsp_t r;
			r.out_char        = ch;
			r.char_valid      = valid;
			r.queue_was_empty = was_empty;
			r.last            = last_flag;
			r.lines_held      = held[3:0];
			expected_chars.push_back(r);
		endfunction

		function void take_request(req_t r);
			int slot;
			int lim;
			int n;
			if (r.cmd == CMD_RX) begin
				if (r.rx_byte == CHAR_CR || r.rx_byte == CHAR_LF) begin
					if (pend_len > 0) begin
						push_line();
						pend_len = 0;
					end
				end else if (pend_len < LINE_LEN - 1) begin
					pend_bytes[pend_len] = r.rx_byte;
					pend_len++;
				end else begin
					push_line();
					pend_len = 0;
				end
				return;
			end
			if (held == 0) begin
				add_expect(8'h00, 1'b0, 1'b1, 1'b1);
				return;
			end
			slot = rd_ptr;
			lim  = (r.out_limit == 0) ? 1 : int'(r.out_limit);
			n    = (slot_len[slot] < lim - 1) ? slot_len[slot] : lim - 1;
			rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
			held--;
			if (n == 0) begin
				add_expect(8'h00, 1'b0, 1'b0, 1'b1);
				return;
			end
			for (int i = 0; i < n; i++)
				add_expect(slot_bytes[slot][i], 1'b1, 1'b0, i == n - 1);
		endfunction

		function void match_result(rsp_t got);
			rsp_t want;
			if (expected_chars.size() == 0) begin
				$error("unexpected result: out_char %0h char_valid %0b last %0b",
					got.out_char, got.char_valid, got.last);
				fails++;
				return;
			end
			want = expected_chars.pop_front();
			if (got.out_char !== want.out_char) begin
				$error("out_char expected %0h, actual %0h", want.out_char, got.out_char);
				fails++;
			end
			if (got.char_valid !== want.char_valid) begin
				$error("char_valid expected %0b, actual %0b", want.char_valid, got.char_valid);
				fails++;
			end
			if (got.queue_was_empty !== want.queue_was_empty) begin
				$error("queue_was_empty expected %0b, actual %0b",
					want.queue_was_empty, got.queue_was_empty);
				fails++;
			end
			if (got.last !== want.last) begin
				$error("last expected %0b, actual %0b", want.last, got.last);
				fails++;
			end
			if (got.lines_held !== want.lines_held) begin
				$error("lines_held expected %0d, actual %0d", want.lines_held, got.lines_held);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	rsp_t result;
	logic result_strobe;

	line_fifo_checker sb = new();

	int sent;
	int burst_left;

	uart_line_assembler_queue_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.result        (result),
		.result_strobe (result_strobe)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watch both sides at every edge. Check results before noting a new request:
	// a result strobed at the edge of an accept always belongs to an older pop.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_strobe)
				sb.match_result(result);
			if (start && !busy)
				sb.take_request(req);
		end
	end

	// Mostly short bursts; now and then a long stretch with no gaps at all.
	function int pick_burst();
		return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(20, 50);
	endfunction

	// Any byte but a terminator; a zero byte shows up often enough to cut lines.
	function logic [7:0] pick_text_byte();
		logic [7:0] b;
		if ($urandom_range(0, 19) == 0)
			return CHAR_NUL;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CHAR_CR || b == CHAR_LF);
		return b;
	endfunction

	// Present one request and hold it until the block takes it; then idle
	// for a random gap once the current burst runs out.
	task automatic issue(input req_t r);
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy);
		sent++;
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = pick_burst();
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		req_t r;
		r.cmd       = CMD_RX;
		r.rx_byte   = b;
		r.out_limit = LIM_W'($urandom_range(0, 127));
		issue(r);
	endtask

	task automatic send_pop(input int lim);
		req_t r;
		r.cmd       = CMD_POP;
		r.rx_byte   = 8'($urandom_range(0, 255));
		r.out_limit = lim[LIM_W-1:0];
		issue(r);
	endtask

	// Send a line of random text and end it with CR or LF.
	task automatic send_line(input int nbytes);
		for (int i = 0; i < nbytes; i++)
			send_byte(pick_text_byte());
		send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
	endtask

	// Drop start and hold off until every predicted result has come out.
	task automatic hold_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_chars.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int   pick;
		req_t noise;

		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		sent       = 0;
		burst_left = pick_burst();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: pop on an empty queue with a zero limit.
		send_pop(0);
		// Terminators with nothing pending do nothing.
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
		// Plain line with the top byte value in it.
		send_byte(8'h48);
		send_byte(8'h69);
		send_byte(8'hFF);
		send_byte(CHAR_LF);
		// A zero byte cuts the stored line short.
		send_byte(8'h41);
		send_byte(CHAR_NUL);
		send_byte(8'h42);
		send_byte(CHAR_CR);
		// Line of a single zero byte: stored with no characters.
		send_byte(CHAR_NUL);
		send_byte(CHAR_CR);
		// Trailing CR after LF is an empty terminator.
		send_byte(8'h7F);
		send_byte(CHAR_LF);
		send_byte(CHAR_CR);
		// Widest limit, limit of one, zero limit, limit of two, then empty again.
		send_pop(127);
		send_pop(1);
		send_pop(0);
		send_pop(2);
		send_pop(64);

		// Make sure the sender pauses at least once until all results are out.
		hold_until_drained();

		// Overflow: 63 bytes fill the line, the 64th pushes it and is dropped,
		// then the terminator finds nothing pending. Pop it whole: 63 results.
		// Keep zero bytes out so the full line is stored.
		for (int i = 0; i < LINE_LEN; i++)
			send_byte(8'($urandom_range(16, 255)));
		send_byte(CHAR_LF);
		send_pop($urandom_range(LINE_LEN, 127));

		// Random traffic: mostly well-formed lines and pops, so the queue fills up,
		// drops lines and drains again; the rest is noise and odd line shapes.
		while (sent < 160) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_line($urandom_range(0, 6));
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 4))
					send_pop(($urandom_range(0, 9) < 7) ? $urandom_range(0, 10)
						: $urandom_range(11, 127));
			end else if (pick < 85) begin
				noise = req_t'(16'($urandom));
				issue(noise);
			end else if (pick < 88) begin
				hold_until_drained();
			end else if (pick < 92) begin
				send_line($urandom_range(20, LINE_LEN + 2));
			end else begin
				send_line($urandom_range(1, 4));
				send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
			end
		end

		// Wait out the results, then leave room for a line copy still in flight.
		hold_until_drained();
		repeat (LINE_LEN + 8) @(posedge clk);

		if (sb.fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Guard against a hang: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
